@@ rtl/core/psob_pkg.sv @@
package psob_pkg;
	localparam int PriceW = 16;
	localparam int AmountW = 16;
	localparam int TraderW = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} opcode_t;

	typedef enum logic {
		SIDE_BUY  = 1'b0,
		SIDE_SELL = 1'b1
	} side_t;

	typedef struct packed {
		logic [PriceW-1:0]  price;
		logic [AmountW-1:0] amount;
		logic [TraderW-1:0] trader;
	} order_t;

	// classified request passed from front to back
	typedef struct packed {
		opcode_t op;
		side_t   side;
		order_t  ord;
	} req_t;

	typedef struct packed {
		logic                accepted;
		logic                book_full;
		logic                match_found;
		logic [TraderW-1:0]  match_trader;
		logic [PriceW-1:0]   match_price;
		logic [AmountW-1:0]  match_amount;
	} rsp_t;
endpackage

@@ rtl/core/psob_front.sv @@
// Input stage: registers the request and holds it until the back end takes it.
module psob_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  psob_pkg::req_t  req_in,
	output logic            req_vld,
	input  logic            req_rdy,
	output psob_pkg::req_t  req_out
);
	import psob_pkg::*;

	localparam int Depth = 2;

	req_t        mem_q [Depth];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        do_push, do_pop;

	assign full    = (cnt_q == 2'(Depth));
	assign req_vld = (cnt_q != 2'd0);
	assign req_out = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = req_vld && req_rdy;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

@@ rtl/core/psob_side.sv @@
// One sorted side: a row of shift-in cells.
module psob_side #(
	parameter int BOOK_DEPTH = 16,
	parameter bit ASCENDING  = 1'b1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ins,
	input  psob_pkg::order_t  ord,
	output logic              is_full,
	output logic              not_empty,
	output psob_pkg::order_t  head
);
	import psob_pkg::*;

	localparam int CntW = $clog2(BOOK_DEPTH + 1);

	order_t          cell_q [BOOK_DEPTH];
	logic [CntW-1:0] cnt_q;
	logic [BOOK_DEPTH-1:0] ahead;  // cell ranks equal or better, stays put

	assign is_full   = (cnt_q == CntW'(BOOK_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = cell_q[0];

	always_comb begin
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			if (CntW'(i) >= cnt_q) begin
				ahead[i] = 1'b0;
			end else if (ASCENDING) begin
				ahead[i] = (cell_q[i].price <= ord.price);
			end else begin
				ahead[i] = (cell_q[i].price >= ord.price);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins && !is_full) begin
			for (int i = 0; i < BOOK_DEPTH; i++) begin
				if (!ahead[i]) begin
					if (i == 0 || ahead[(i == 0) ? 0 : i-1]) begin
						cell_q[i] <= ord;
					end else begin
						cell_q[i] <= cell_q[(i == 0) ? 0 : i-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ins && !is_full) begin
			cnt_q <= cnt_q + CntW'(1);
		end
	end
endmodule

@@ rtl/core/psob_back.sv @@
// Back end: executes requests on both sides and holds a two-entry result queue.
module psob_back #(
	parameter int BOOK_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_vld,
	output logic            req_rdy,
	input  psob_pkg::req_t  req,
	output logic            empty,
	input  logic            pop,
	output psob_pkg::rsp_t  rsp
);
	import psob_pkg::*;

	order_t buy_head, sell_head;
	logic   buy_full, sell_full, buy_ne, sell_ne;
	logic   take, ins_buy, ins_sell;
	rsp_t   res;
	rsp_t   q_q [2];
	logic   wp_q, rp_q;
	logic [1:0] cnt_q;
	logic   do_pop;

	assign req_rdy  = (cnt_q != 2'd2);
	assign take     = req_vld && req_rdy;
	assign ins_buy  = take && req.op == OP_INSERT && req.side == SIDE_BUY;
	assign ins_sell = take && req.op == OP_INSERT && req.side == SIDE_SELL;

	psob_side #(.BOOK_DEPTH(BOOK_DEPTH), .ASCENDING(1'b0)) u_buy (
		.clk, .arst_n, .ins(ins_buy), .ord(req.ord),
		.is_full(buy_full), .not_empty(buy_ne), .head(buy_head)
	);
	psob_side #(.BOOK_DEPTH(BOOK_DEPTH), .ASCENDING(1'b1)) u_sell (
		.clk, .arst_n, .ins(ins_sell), .ord(req.ord),
		.is_full(sell_full), .not_empty(sell_ne), .head(sell_head)
	);

	always_comb begin
		res = '0;
		if (req.op == OP_INSERT) begin
			res.book_full = (req.side == SIDE_BUY) ? buy_full : sell_full;
			res.accepted  = ~res.book_full;
		end else if (req.side == SIDE_BUY) begin
			if (sell_ne && sell_head.price <= req.ord.price) begin
				res.match_found  = 1'b1;
				res.match_trader = sell_head.trader;
				res.match_price  = sell_head.price;
				res.match_amount = sell_head.amount;
			end
		end else begin
			if (buy_ne && buy_head.price >= req.ord.price) begin
				res.match_found  = 1'b1;
				res.match_trader = buy_head.trader;
				res.match_price  = buy_head.price;
				res.match_amount = buy_head.amount;
			end
		end
	end

	assign empty  = (cnt_q == 2'd0);
	assign rsp    = q_q[rp_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (take) q_q[wp_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (take)   wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(take) - 2'(do_pop);
		end
	end
endmodule

@@ rtl/core/price_sorted_order_book.sv @@
// Channel   | Handshake            | Fields
// ----------+----------------------+----------------------------------------------
// request   | push / full          | opcode, order_side, order_price, order_amount,
//           |                      | trader_id
// result    | empty / pop          | accepted, book_full, match_found,
//           |                      | match_trader, match_price, match_amount
//
// One request per cycle sustained while results are popped; a request waits in the
// front queue, then the back end's sorted insert or head compare fills the back queue.
// Each side is a row of BOOK_DEPTH shift-in cells, so an insert compares against every cell in parallel.
// arst_n clears both order counts and both queues; cell contents stay unknown.
// A stalled result side fills the back queue, then the front queue, then full rises.
module price_sorted_order_book #(
	parameter int BOOK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic        order_side,
	input  logic [15:0] order_price,
	input  logic [15:0] order_amount,
	input  logic [15:0] trader_id,
	output logic        empty,
	input  logic        pop,
	output logic        accepted,
	output logic        book_full,
	output logic        match_found,
	output logic [15:0] match_trader,
	output logic [15:0] match_price,
	output logic [15:0] match_amount
);
	import psob_pkg::*;

	req_t req_in, req_q;
	logic req_vld, req_rdy;
	rsp_t rsp;

	// pack incoming request
	assign req_in.op         = opcode_t'(opcode);
	assign req_in.side       = side_t'(order_side);
	assign req_in.ord.price  = order_price;
	assign req_in.ord.amount = order_amount;
	assign req_in.ord.trader = trader_id;

	psob_front u_front (
		.clk, .arst_n, .push, .full, .req_in,
		.req_vld, .req_rdy, .req_out(req_q)
	);

	psob_back #(.BOOK_DEPTH(BOOK_DEPTH)) u_back (
		.clk, .arst_n, .req_vld, .req_rdy, .req(req_q),
		.empty, .pop, .rsp
	);

	assign accepted     = rsp.accepted;
	assign book_full    = rsp.book_full;
	assign match_found  = rsp.match_found;
	assign match_trader = rsp.match_trader;
	assign match_price  = rsp.match_price;
	assign match_amount = rsp.match_amount;
endmodule

@@ rtl/core/psob_checker.sv @@
module psob_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic        accepted,
	input logic        book_full,
	input logic        match_found,
	input logic [15:0] match_trader,
	input logic [15:0] match_price,
	input logic [15:0] match_amount
);
	// a result is at most one kind
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(accepted && book_full) && !((accepted || book_full) && match_found))
		else $error("result kind not exclusive");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !match_found |-> match_trader == 16'd0 && match_price == 16'd0
		&& match_amount == 16'd0)
		else $error("match fields nonzero without match");

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && empty |=> ##1 !empty)
		else $error("result late");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(match_price) && $stable(accepted))
		else $error("stalled result changed");
endmodule

bind price_sorted_order_book psob_checker u_chk (.*);

@@ test/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import psob_pkg::*;

	localparam int Depth = 16;
	localparam int RandomOrders = 1700;
	localparam int CycleLimit = 400000;

	// One predicted result of the order book.
	typedef struct {
		logic        accepted;
		logic        book_full;
		logic        match_found;
		logic [15:0] match_trader;
		logic [15:0] match_price;
		logic [15:0] match_amount;
	} book_rsp_t;

	// Tracks both sorted tables and the queue of results still owed by the DUT.
	class book_scoreboard;
		order_t      sells[$];
		order_t      buys[$];
		book_rsp_t   owed[$];
		int          errors;
		int          checked;
		int          fills;
		int          hits;

		function void note_request(opcode_t op, side_t sd, order_t o);
			book_rsp_t r;
			int        pos;
			r = '{default: '0};
			if (op == OP_INSERT) begin
				if (sd == SIDE_BUY) begin
					if (buys.size() >= Depth) begin
						r.book_full = 1'b1;
					end else begin
						// sits behind every buy priced at or above it
						pos = 0;
						while (pos < buys.size() && buys[pos].price >= o.price) pos++;
						buys.insert(pos, o);
						r.accepted = 1'b1;
					end
				end else begin
					if (sells.size() >= Depth) begin
						r.book_full = 1'b1;
					end else begin
						pos = 0;
						while (pos < sells.size() && sells[pos].price <= o.price) pos++;
						sells.insert(pos, o);
						r.accepted = 1'b1;
					end
				end
				if (r.book_full) fills++;
			end else begin
				// buy query crosses the best sell, sell query the best buy
				if (sd == SIDE_BUY && sells.size() > 0 && sells[0].price <= o.price) begin
					r.match_found = 1'b1;
					r.match_trader = sells[0].trader;
					r.match_price = sells[0].price;
					r.match_amount = sells[0].amount;
				end else if (sd == SIDE_SELL && buys.size() > 0 &&
						buys[0].price >= o.price) begin
					r.match_found = 1'b1;
					r.match_trader = buys[0].trader;
					r.match_price = buys[0].price;
					r.match_amount = buys[0].amount;
				end
				if (r.match_found) hits++;
			end
			owed.insert(owed.size(), r);
		endfunction

		function void check_result(book_rsp_t got);
			book_rsp_t want;
			if (owed.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			want = owed.pop_front();
			checked++;
			if (got.accepted !== want.accepted) begin
				$error("accepted exp %0d got %0d", want.accepted, got.accepted);
				errors++;
			end
			if (got.book_full !== want.book_full) begin
				$error("book_full exp %0d got %0d", want.book_full, got.book_full);
				errors++;
			end
			if (got.match_found !== want.match_found) begin
				$error("match_found exp %0d got %0d", want.match_found, got.match_found);
				errors++;
			end
			if (got.match_trader !== want.match_trader) begin
				$error("match_trader exp %h got %h", want.match_trader, got.match_trader);
				errors++;
			end
			if (got.match_price !== want.match_price) begin
				$error("match_price exp %h got %h", want.match_price, got.match_price);
				errors++;
			end
			if (got.match_amount !== want.match_amount) begin
				$error("match_amount exp %h got %h", want.match_amount, got.match_amount);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        opcode;
	logic        order_side;
	logic [15:0] order_price;
	logic [15:0] order_amount;
	logic [15:0] trader_id;
	logic        empty;
	logic        pop;
	logic        accepted;
	logic        book_full;
	logic        match_found;
	logic [15:0] match_trader;
	logic [15:0] match_price;
	logic [15:0] match_amount;

	book_scoreboard sb;
	int  cycle;
	bit  calm;         // no random idling on either side
	bit  drain_hold;   // receiver holds off entirely
	int  sent;

	price_sorted_order_book #(.BOOK_DEPTH(Depth)) DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .order_side(order_side), .order_price(order_price),
		.order_amount(order_amount), .trader_id(trader_id),
		.empty(empty), .pop(pop), .accepted(accepted), .book_full(book_full),
		.match_found(match_found), .match_trader(match_trader),
		.match_price(match_price), .match_amount(match_amount)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Monitor: requests and results are both taken at the rising edge.
	always @(posedge clk) begin
		book_rsp_t got;
		if (arst_n) begin
			if (push && !full)
				sb.note_request(opcode_t'(opcode), side_t'(order_side),
					'{price: order_price, amount: order_amount, trader: trader_id});
			if (pop && !empty) begin
				got.accepted = accepted;
				got.book_full = book_full;
				got.match_found = match_found;
				got.match_trader = match_trader;
				got.match_price = match_price;
				got.match_amount = match_amount;
				sb.check_result(got);
			end
		end
	end

	// Receiver: pop changes on the falling edge.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (drain_hold) pop <= 1'b0;
			else if (calm) pop <= 1'b1;
			else pop <= ($urandom_range(99) >= 15);
		end
	end

	// Offers one request, holding it until the DUT takes it.
	task automatic send(opcode_t op, side_t sd, logic [15:0] p, logic [15:0] a,
			logic [15:0] t);
		if (!calm) begin
			while ($urandom_range(99) < 15) begin
				push <= 1'b0;
				@(negedge clk);
			end
		end
		push <= 1'b1;
		opcode <= op;
		order_side <= sd;
		order_price <= p;
		order_amount <= a;
		trader_id <= t;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic idle_push();
		push <= 1'b0;
	endtask

	task automatic wait_drained();
		idle_push();
		while (sb.owed.size() != 0) @(negedge clk);
	endtask

	// Clearing the tables needs a reset, which happens only once, so the random
	// part keeps the books churning by mixing queries with inserts; once a side
	// fills, further inserts on it exercise the full path.
	task automatic random_item(int price_span);
		opcode_t     op;
		side_t       sd;
		logic [15:0] p;
		op = ($urandom_range(99) < 60) ? OP_QUERY : OP_INSERT;
		sd = side_t'($urandom_range(1));
		case ($urandom_range(9))
			0: p = 16'h0000;
			1: p = 16'hffff;
			2: p = 16'($urandom);
			default: p = 16'(16'h8000 + $urandom_range(price_span) - price_span / 2);
		endcase
		send(op, sd, p, 16'($urandom), 16'($urandom));
	endtask

	initial begin
		int hold;
		sb = new();
		cycle = 0;
		calm = 1'b0;
		drain_hold = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		push = 1'b0;
		opcode = OP_INSERT;
		order_side = SIDE_BUY;
		order_price = '0;
		order_amount = '0;
		trader_id = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: queries on empty tables, extremes, equal-price ordering.
		send(OP_QUERY, SIDE_BUY, 16'hffff, 16'hffff, 16'hffff);
		send(OP_QUERY, SIDE_SELL, 16'h0000, 16'hffff, 16'hffff);
		send(OP_INSERT, SIDE_SELL, 16'hffff, 16'hffff, 16'hffff);
		send(OP_INSERT, SIDE_BUY, 16'h0000, 16'h0000, 16'h0000);
		send(OP_QUERY, SIDE_BUY, 16'hfffe, 16'h0, 16'h0);   // no cross
		send(OP_QUERY, SIDE_BUY, 16'hffff, 16'h0, 16'h0);   // equal price crosses
		send(OP_QUERY, SIDE_SELL, 16'h0001, 16'h0, 16'h0);
		send(OP_QUERY, SIDE_SELL, 16'h0000, 16'h0, 16'h0);
		send(OP_INSERT, SIDE_SELL, 16'h1000, 16'h0011, 16'h0aaa);
		send(OP_INSERT, SIDE_SELL, 16'h1000, 16'h0022, 16'h0bbb); // later, stays behind
		send(OP_INSERT, SIDE_BUY, 16'h2000, 16'h0033, 16'h0ccc);
		send(OP_INSERT, SIDE_BUY, 16'h2000, 16'h0044, 16'h0ddd);
		send(OP_QUERY, SIDE_BUY, 16'h1000, 16'h0, 16'h0);
		send(OP_QUERY, SIDE_SELL, 16'h2000, 16'h0, 16'h0);
		// Fill the sell side, then overflow it.
		for (int i = 0; i < Depth; i++)
			send(OP_INSERT, SIDE_SELL, 16'($urandom_range(16'h0fff)), 16'($urandom),
				16'($urandom));
		send(OP_QUERY, SIDE_BUY, 16'h0fff, 16'h0, 16'h0);
		wait_drained();

		// Long back-pressure stretch: receiver stops, sender keeps going.
		drain_hold = 1'b1;
		fork
			begin
				hold = 0;
				while (hold < 60) begin
					@(posedge clk);
					hold++;
				end
				drain_hold = 1'b0;
			end
			repeat (20) random_item(4096);
		join

		// Stretch with no idling at all.
		calm = 1'b1;
		repeat (300) random_item(4096);
		calm = 1'b0;

		// Sender pause until all results are in.
		wait_drained();

		for (int i = 0; i < RandomOrders - 320; i++)
			random_item(($urandom_range(3) == 0) ? 65535 : 2048);

		wait_drained();
		repeat (10) @(negedge clk);

		$display("Sent %0d requests, checked %0d results: %0d full-table drops, %0d matches.",
			sent, sb.checked, sb.fills, sb.hits);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

@@ sim.f @@
rtl/core/psob_pkg.sv
rtl/core/psob_front.sv
rtl/core/psob_side.sv
rtl/core/psob_back.sv
rtl/core/price_sorted_order_book.sv
rtl/core/psob_checker.sv
test/tb_top.sv
